// File: src/mkpc_pkg.sv
`default_nettype none

package mkpc_pkg;

  // Key count, clamped to the eight keys that the pin field can carry
  localparam int NUM_KEYS  = 8;
  localparam int KEY_COUNT = (NUM_KEYS > 8) ? 8 : ((NUM_KEYS < 1) ? 1 : NUM_KEYS);
  localparam int KEY_W     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int CNT_W     = $clog2(KEY_COUNT + 1);

  // Field widths
  localparam int TS_W      = 32;
  localparam int PIN_W     = 8;
  localparam int KEY_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 8;
  localparam int IN_W      = 40;
  localparam int OUT_W     = 8;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 8'd1;
  localparam logic [CFG_W-1:0]     DEBOUNCE_RST   = 16'd20;
  localparam logic [CFG_W-1:0]     LONG_PRESS_RST = 16'd1000;

  typedef enum logic [1:0] {
    M_IDLE     = 2'd0,
    M_DEBOUNCE = 2'd1,
    M_PRESSED  = 2'd2,
    M_LONG     = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_e;

  // One memory entry per key
  typedef struct packed {
    mode_e            mode;
    logic [TS_W-1:0]  stamp;
    logic             valid;
  } key_state_t;

  localparam key_state_t KEY_RESET = '{mode: M_IDLE, stamp: '0, valid: 1'b0};

  typedef struct packed {
    logic [CFG_W-1:0] debounce;
    logic [CFG_W-1:0] long_press;
  } cfg_t;

  // State memory port requests from the engine
  typedef struct packed {
    logic             rd_en;
    logic [KEY_W-1:0] rd_addr;
    logic             wr_en;
    logic [KEY_W-1:0] wr_addr;
    key_state_t       wr_data;
  } ram_req_t;

  typedef struct packed {
    key_state_t st;
    event_e     ev;
  } key_upd_t;

  // Next state and event of one key for one scan tick
  function automatic key_upd_t key_update(key_state_t s, logic [TS_W-1:0] now, logic low,
                                          logic [CFG_W-1:0] deb, logic [CFG_W-1:0] lng);
    key_upd_t        r;
    logic [TS_W-1:0] elapsed;
    r       = '{st: s, ev: EV_NONE};
    elapsed = now - s.stamp;
    unique case (s.mode)
      M_IDLE: begin
        if (low) begin
          r.st.mode  = M_DEBOUNCE;
          r.st.stamp = now;
        end
      end
      M_DEBOUNCE: begin
        if (!low) begin
          r.st.mode = M_IDLE;
        end else if (elapsed >= {{(TS_W-CFG_W){1'b0}}, deb}) begin
          r.st.mode  = M_PRESSED;
          r.st.valid = 1'b1;
        end
      end
      M_PRESSED: begin
        if (!low) begin
          if (s.valid) begin
            r.ev       = EV_SHORT;
            r.st.valid = 1'b0;
          end
          r.st.mode = M_IDLE;
        end else if (elapsed >= {{(TS_W-CFG_W){1'b0}}, lng}) begin
          if (s.valid) begin
            r.ev       = EV_LONG;
            r.st.valid = 1'b0;
          end
          r.st.mode = M_LONG;
        end
      end
      default: begin
        if (!low) r.st.mode = M_IDLE;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/mkpc_state_ram.sv
`default_nettype none

// Per-key state memory, one read and one write port, registered read data.
// Entries never written since reset read as the idle state.
module mkpc_state_ram (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire mkpc_pkg::ram_req_t    req_i,
  output mkpc_pkg::key_state_t       rd_data_o
);

  mkpc_pkg::key_state_t                    mem [mkpc_pkg::KEY_COUNT];
  mkpc_pkg::key_state_t                    mem_rd_q;
  logic [mkpc_pkg::KEY_COUNT-1:0]          vld_q;
  logic                                    rd_vld_q;

  // Written flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) vld_q[req_i.wr_addr] <= 1'b1;
      if (req_i.rd_en) rd_vld_q <= vld_q[req_i.rd_addr];
    end
  end

  // Storage array
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) mem[req_i.wr_addr] <= req_i.wr_data;
    if (req_i.rd_en) mem_rd_q <= mem[req_i.rd_addr];
  end

  assign rd_data_o = rd_vld_q ? mem_rd_q : mkpc_pkg::KEY_RESET;

endmodule

`default_nettype wire

// File: src/mkpc_engine.sv
`default_nettype none

// Scan-tick sequencer: read-modify-write pass over all keys, then one
// result transfer per key.
module mkpc_engine (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire mkpc_pkg::cfg_t          cfg_i,
  // tdata: timestamp_ms [31:0], pin_levels [39:32]
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [mkpc_pkg::IN_W-1:0]    s_axis_tdata,
  // tdata: key_index [2:0], key_event [4:3], key_held [5], any_held [6], pad [7]
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [mkpc_pkg::OUT_W-1:0]   m_axis_tdata,
  output logic                         m_axis_tlast,
  output mkpc_pkg::ram_req_t           ram_req_o,
  input  wire mkpc_pkg::key_state_t    ram_rd_i
);

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_UPD  = 2'd1,
    S_EMIT = 2'd2
  } state_e;

  localparam logic [mkpc_pkg::CNT_W-1:0] ISS_END = mkpc_pkg::CNT_W'(mkpc_pkg::KEY_COUNT);
  localparam logic [mkpc_pkg::KEY_W-1:0] KEY_LAST =
    mkpc_pkg::KEY_W'(mkpc_pkg::KEY_COUNT - 1);

  state_e                              state_q;
  logic [mkpc_pkg::CNT_W-1:0]          iss_q;
  logic                                pend_q;
  logic [mkpc_pkg::KEY_W-1:0]          wb_q;
  logic [mkpc_pkg::KEY_W-1:0]          em_q;
  logic                                any_q;
  logic [mkpc_pkg::TS_W-1:0]           now_q;
  logic [mkpc_pkg::KEY_COUNT-1:0]      pins_q;
  mkpc_pkg::event_e                    ev_q [mkpc_pkg::KEY_COUNT];
  logic [mkpc_pkg::KEY_COUNT-1:0]      held_q;
  mkpc_pkg::key_upd_t                  upd;
  logic                                held_new;
  logic                                in_xfer;
  logic                                out_xfer;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state_q == S_EMIT);
  assign out_xfer      = m_axis_tvalid && m_axis_tready;
  assign m_axis_tlast  = (em_q == KEY_LAST);
  assign m_axis_tdata  = {1'b0, any_q, held_q[em_q], ev_q[em_q],
                          (mkpc_pkg::KEY_IDX_W)'(em_q)};

  // Key update on the entry read last cycle, and memory requests
  always_comb begin
    upd      = mkpc_pkg::key_update(ram_rd_i, now_q, ~pins_q[wb_q],
                                    cfg_i.debounce, cfg_i.long_press);
    held_new = (upd.st.mode == mkpc_pkg::M_PRESSED) || (upd.st.mode == mkpc_pkg::M_LONG);
    ram_req_o         = '0;
    ram_req_o.wr_en   = (state_q == S_UPD) && pend_q;
    ram_req_o.wr_addr = wb_q;
    ram_req_o.wr_data = upd.st;
    if (state_q == S_IDLE) begin
      ram_req_o.rd_en   = s_axis_tvalid;
      ram_req_o.rd_addr = '0;
    end else if ((state_q == S_UPD) && (iss_q != ISS_END)) begin
      ram_req_o.rd_en   = 1'b1;
      ram_req_o.rd_addr = iss_q[mkpc_pkg::KEY_W-1:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iss_q   <= '0;
      pend_q  <= 1'b0;
      wb_q    <= '0;
      em_q    <= '0;
      any_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            state_q <= S_UPD;
            iss_q   <= mkpc_pkg::CNT_W'(1);
            pend_q  <= 1'b1;
            wb_q    <= '0;
            any_q   <= 1'b0;
          end
        end
        S_UPD: begin
          if (pend_q && held_new) any_q <= 1'b1;
          if (iss_q != ISS_END) begin
            wb_q  <= iss_q[mkpc_pkg::KEY_W-1:0];
            iss_q <= iss_q + mkpc_pkg::CNT_W'(1);
          end else begin
            pend_q  <= 1'b0;
            state_q <= S_EMIT;
            em_q    <= '0;
          end
        end
        S_EMIT: begin
          if (out_xfer) begin
            if (m_axis_tlast) state_q <= S_IDLE;
            else em_q <= em_q + mkpc_pkg::KEY_W'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Tick payload and per-key results
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      now_q  <= s_axis_tdata[mkpc_pkg::TS_W-1:0];
      pins_q <= s_axis_tdata[mkpc_pkg::TS_W +: mkpc_pkg::KEY_COUNT];
    end
    if (ram_req_o.wr_en) begin
      ev_q[wb_q]   <= upd.ev;
      held_q[wb_q] <= held_new;
    end
  end

  // A read and the write-back never hit the same entry together
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_req_o.rd_en && ram_req_o.wr_en) |-> (ram_req_o.rd_addr != ram_req_o.wr_addr))
    else $error("state memory read and write on the same entry");

  // Each write-back follows a read issued the cycle before
  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req_o.wr_en |-> $past(ram_req_o.rd_en))
    else $error("write-back without a preceding read");

  // Results and new ticks never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(m_axis_tvalid && s_axis_tready))
    else $error("tick accepted while results pending");

  // The final result of a tick frees the input side
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && m_axis_tlast) |=> s_axis_tready)
    else $error("input not ready after final result");

endmodule

`default_nettype wire

// File: src/multi_key_press_classifier.sv
`default_nettype none

// Flow: a tick is taken, then each key in turn updates its memory entry
// in the state memory, then one result per key follows, one per cycle
// while the sink is ready. A new tick is taken only once the last result
// of the current tick has been transferred.
// Reset: asynchronous, active low; registers return to 20 / 1000 ms, all keys
// read as idle at once through per-entry written flags, no clearing pass.
module multi_key_press_classifier (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // Configuration write channel
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  [mkpc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire  [mkpc_pkg::CFG_W-1:0]         cfg_data_i,
  // tdata: timestamp_ms [31:0], pin_levels [39:32]
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [mkpc_pkg::IN_W-1:0]          s_axis_tdata,
  // tdata: key_index [2:0], key_event [4:3], key_held [5], any_held [6], pad [7]
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [mkpc_pkg::OUT_W-1:0]         m_axis_tdata,
  output logic                               m_axis_tlast
);

  mkpc_pkg::cfg_t        cfg_q;
  mkpc_pkg::ram_req_t    ram_req;
  mkpc_pkg::key_state_t  ram_rd;

  assign cfg_ready_o = 1'b1;

  // Configuration registers; writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce   <= mkpc_pkg::DEBOUNCE_RST;
      cfg_q.long_press <= mkpc_pkg::LONG_PRESS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        mkpc_pkg::CFG_DEBOUNCE:   cfg_q.debounce   <= cfg_data_i;
        mkpc_pkg::CFG_LONG_PRESS: cfg_q.long_press <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mkpc_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .ram_req_o     (ram_req),
    .ram_rd_i      (ram_rd)
  );

  mkpc_state_ram u_state_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ram_req),
    .rd_data_o (ram_rd)
  );

endmodule

`default_nettype wire

// File: tb/multi_key_press_classifier_tb.sv
`timescale 1ns / 100ps

module multi_key_press_classifier_tb;

  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 2 * mkpc_pkg::KEY_COUNT + 4;
  localparam int DIR_ROWS     = 26;

  // Index outside the register list, written to check it is ignored
  localparam logic [mkpc_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = mkpc_pkg::CFG_LONG_PRESS + 8'd1;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;
  typedef enum int {SINK_OPEN, SINK_HALF, SINK_SPARSE, SINK_TOGGLE} sink_mode_e;

  // One key result as it should appear on the output stream
  typedef struct packed {
    logic [mkpc_pkg::KEY_IDX_W-1:0] idx;
    mkpc_pkg::event_e               ev;
    logic                           held;
    logic                           any;
    logic                           last;
  } key_report_t;

  // Directed row: a scan tick (optionally with typed-in result) or a register write
  typedef struct packed {
    row_kind_e                      kind;
    logic                           chk;
    logic [mkpc_pkg::TS_W-1:0]      ts;
    logic [mkpc_pkg::PIN_W-1:0]     pins;
    logic [7:0]                     held;
    logic [7:0]                     ev_short;
    logic [7:0]                     ev_long;
    logic [mkpc_pkg::CFG_IDX_W-1:0] idx;
    logic [mkpc_pkg::CFG_W-1:0]     val;
  } dir_row_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [mkpc_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [mkpc_pkg::CFG_W-1:0]     cfg_data_i;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [mkpc_pkg::IN_W-1:0]      s_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [mkpc_pkg::OUT_W-1:0]     m_axis_tdata;
  logic                           m_axis_tlast;

  // Shadow of the key state and registers
  mkpc_pkg::mode_e            key_mode  [mkpc_pkg::KEY_COUNT];
  logic [mkpc_pkg::TS_W-1:0]  key_stamp [mkpc_pkg::KEY_COUNT];
  logic                       key_valid [mkpc_pkg::KEY_COUNT];
  logic [mkpc_pkg::CFG_W-1:0] deb_cfg;
  logic [mkpc_pkg::CFG_W-1:0] lng_cfg;

  key_report_t tick_reports [mkpc_pkg::KEY_COUNT];
  key_report_t key_report_q [$];
  int          mismatch_cnt = 0;
  int          burst_left   = 0;
  bit          hold_req     = 1'b0;
  bit          hold_done    = 1'b0;

  // Reset config first, then zero debounce / zero long press
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_TICK, 1'b1, 32'd0,          8'hFF, 8'h00, 8'h00, 8'h00, 8'd0, 16'd0},
    '{ROW_TICK, 1'b1, 32'd100,        8'hFE, 8'h00, 8'h00, 8'h00, 8'd0, 16'd0},
    '{ROW_TICK, 1'b1, 32'd110,        8'hFE, 8'h00, 8'h00, 8'h00, 8'd0, 16'd0},
    '{ROW_TICK, 1'b1, 32'd120,        8'hFE, 8'h01, 8'h00, 8'h00, 8'd0, 16'd0},
    '{ROW_TICK, 1'b1, 32'd130,        8'hFF, 8'h00, 8'h01, 8'h00, 8'd0, 16'd0},
    '{ROW_TICK, 1'b1, 32'd200,        8'h00, 8'h00, 8'h00, 8'h00, 8'd0, 16'd0},
    '{ROW_TICK, 1'b1, 32'd220,        8'h00, 8'hFF, 8'h00, 8'h00, 8'd0, 16'd0},
    '{ROW_TICK, 1'b1, 32'd1200,       8'h00, 8'hFF, 8'h00, 8'hFF, 8'd0, 16'd0},
    '{ROW_TICK, 1'b1, 32'd1300,       8'h00, 8'hFF, 8'h00, 8'h00, 8'd0, 16'd0},
    '{ROW_TICK, 1'b1, 32'd1400,       8'hFF, 8'h00, 8'h00, 8'h00, 8'd0, 16'd0},
    // bounce on key 7, then timestamps wrapping and stepping back
    '{ROW_TICK, 1'b0, 32'd1500,       8'h7F, 8'h00, 8'h00, 8'h00, 8'd0, 16'd0},
    '{ROW_TICK, 1'b0, 32'd1505,       8'hFF, 8'h00, 8'h00, 8'h00, 8'd0, 16'd0},
    '{ROW_TICK, 1'b0, 32'd1600,       8'h7F, 8'h00, 8'h00, 8'h00, 8'd0, 16'd0},
    '{ROW_TICK, 1'b0, 32'hFFFF_FFF8,  8'h3F, 8'h00, 8'h00, 8'h00, 8'd0, 16'd0},
    '{ROW_TICK, 1'b0, 32'h0000_000C,  8'h3F, 8'h00, 8'h00, 8'h00, 8'd0, 16'd0},
    '{ROW_TICK, 1'b0, 32'h0000_0005,  8'h3F, 8'h00, 8'h00, 8'h00, 8'd0, 16'd0},
    '{ROW_TICK, 1'b0, 32'hFFFF_FF00,  8'hBF, 8'h00, 8'h00, 8'h00, 8'd0, 16'd0},
    '{ROW_TICK, 1'b0, 32'hFFFF_FF10,  8'hFF, 8'h00, 8'h00, 8'h00, 8'd0, 16'd0},
    '{ROW_CFG,  1'b0, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00, mkpc_pkg::CFG_DEBOUNCE,   16'd0},
    '{ROW_CFG,  1'b0, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00, mkpc_pkg::CFG_LONG_PRESS, 16'd0},
    '{ROW_CFG,  1'b0, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00, CFG_IDX_SPARE,  16'hFFFF},
    '{ROW_TICK, 1'b1, 32'd5000,       8'hFE, 8'h00, 8'h00, 8'h00, 8'd0, 16'd0},
    '{ROW_TICK, 1'b1, 32'd5000,       8'hFE, 8'h01, 8'h00, 8'h00, 8'd0, 16'd0},
    '{ROW_TICK, 1'b1, 32'd5000,       8'hFE, 8'h01, 8'h00, 8'h01, 8'd0, 16'd0},
    '{ROW_TICK, 1'b1, 32'd5001,       8'h55, 8'h00, 8'h00, 8'h00, 8'd0, 16'd0},
    '{ROW_TICK, 1'b1, 32'd5001,       8'hAA, 8'h00, 8'h00, 8'h00, 8'd0, 16'd0}
  };

  multi_key_press_classifier dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatch_cnt++;
  endtask

  // Advance every key by one scan tick and fill tick_reports
  function automatic void classify_tick(logic [mkpc_pkg::TS_W-1:0] now,
                                        logic [mkpc_pkg::PIN_W-1:0] pins);
    logic [mkpc_pkg::TS_W-1:0] since;
    logic                      low;
    logic                      any;
    mkpc_pkg::event_e          ev [mkpc_pkg::KEY_COUNT];
    any = 1'b0;
    for (int k = 0; k < mkpc_pkg::KEY_COUNT; k++) begin
      since = now - key_stamp[k];
      low   = ~pins[k];
      ev[k] = mkpc_pkg::EV_NONE;
      unique case (key_mode[k])
        mkpc_pkg::M_IDLE: begin
          if (low) begin
            key_mode[k]  = mkpc_pkg::M_DEBOUNCE;
            key_stamp[k] = now;
          end
        end
        mkpc_pkg::M_DEBOUNCE: begin
          if (!low) begin
            key_mode[k] = mkpc_pkg::M_IDLE;
          end else if (since >= deb_cfg) begin
            key_mode[k]  = mkpc_pkg::M_PRESSED;
            key_valid[k] = 1'b1;
          end
        end
        mkpc_pkg::M_PRESSED: begin
          if (!low) begin
            if (key_valid[k]) begin
              ev[k]        = mkpc_pkg::EV_SHORT;
              key_valid[k] = 1'b0;
            end
            key_mode[k] = mkpc_pkg::M_IDLE;
          end else if (since >= lng_cfg) begin
            if (key_valid[k]) begin
              ev[k]        = mkpc_pkg::EV_LONG;
              key_valid[k] = 1'b0;
            end
            key_mode[k] = mkpc_pkg::M_LONG;
          end
        end
        default: begin
          if (!low) key_mode[k] = mkpc_pkg::M_IDLE;
        end
      endcase
      any |= (key_mode[k] == mkpc_pkg::M_PRESSED) || (key_mode[k] == mkpc_pkg::M_LONG);
    end
    for (int k = 0; k < mkpc_pkg::KEY_COUNT; k++) begin
      tick_reports[k].idx  = k[mkpc_pkg::KEY_IDX_W-1:0];
      tick_reports[k].ev   = ev[k];
      tick_reports[k].held = (key_mode[k] == mkpc_pkg::M_PRESSED) ||
                             (key_mode[k] == mkpc_pkg::M_LONG);
      tick_reports[k].any  = any;
      tick_reports[k].last = (k == mkpc_pkg::KEY_COUNT - 1);
    end
  endfunction

  // Offer one tick, wait for its transfer, queue its key results
  task automatic send_tick(logic [mkpc_pkg::TS_W-1:0] now, logic [mkpc_pkg::PIN_W-1:0] pins,
                           logic typed, logic [7:0] held, logic [7:0] ev_s, logic [7:0] ev_l);
    key_report_t rep;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pins, now};
    do begin
      @(posedge clk_i);
    end while (s_axis_tready !== 1'b1);
    classify_tick(now, pins);
    for (int k = 0; k < mkpc_pkg::KEY_COUNT; k++) begin
      if (typed) begin
        rep.idx  = k[mkpc_pkg::KEY_IDX_W-1:0];
        rep.ev   = ev_s[k] ? mkpc_pkg::EV_SHORT :
                   (ev_l[k] ? mkpc_pkg::EV_LONG : mkpc_pkg::EV_NONE);
        rep.held = held[k];
        rep.any  = |held;
        rep.last = (k == mkpc_pkg::KEY_COUNT - 1);
      end else begin
        rep = tick_reports[k];
      end
      key_report_q.push_back(rep);
    end
  endtask

  // Sender bursts: random gap once the current burst runs out
  task automatic sender_idle();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
  endtask

  // Register write, only once the block has drained
  task automatic write_reg(logic [mkpc_pkg::CFG_IDX_W-1:0] idx,
                           logic [mkpc_pkg::CFG_W-1:0] val);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (key_report_q.size() != 0) @(posedge clk_i);
    repeat (2 * mkpc_pkg::KEY_COUNT + 1) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(posedge clk_i);
    end while (cfg_ready_o !== 1'b1);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    unique case (idx)
      mkpc_pkg::CFG_DEBOUNCE:   deb_cfg = val;
      mkpc_pkg::CFG_LONG_PRESS: lng_cfg = val;
      default: ;
    endcase
  endtask

  // Key levels that mostly persist, time steps scaled to the current registers
  task automatic random_phase(int n_ticks, bit steady);
    logic [mkpc_pkg::TS_W-1:0]  now;
    logic [mkpc_pkg::PIN_W-1:0] pins;
    logic [mkpc_pkg::PIN_W-1:0] flips;
    int unsigned                scale;
    int                         roll;
    now   = $urandom;
    pins  = '1;
    scale = ((deb_cfg > lng_cfg) ? deb_cfg : lng_cfg) / 3 + 4;
    repeat (n_ticks) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) now = $urandom;
      else if (roll < 12) now = now - $urandom_range(1, scale);
      else now = now + $urandom_range(0, scale);
      if ($urandom_range(0, 99) < 8) begin
        pins = mkpc_pkg::PIN_W'($urandom);
      end else begin
        for (int k = 0; k < mkpc_pkg::PIN_W; k++) flips[k] = ($urandom_range(0, 99) < 15);
        pins ^= flips;
      end
      send_tick(now, pins, 1'b0, 8'h00, 8'h00, 8'h00);
      if (!steady) sender_idle();
    end
  endtask

  // Output check against the oldest queued result
  always @(posedge clk_i) begin : result_check
    key_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (key_report_q.size() == 0) begin
        report_mismatch("result with none pending", m_axis_tdata, 0);
      end else begin
        want = key_report_q.pop_front();
        if (m_axis_tdata[2:0] != want.idx)  report_mismatch("key_index", m_axis_tdata[2:0], want.idx);
        if (m_axis_tdata[4:3] != want.ev)   report_mismatch("key_event", m_axis_tdata[4:3], want.ev);
        if (m_axis_tdata[5] != want.held)   report_mismatch("key_held", m_axis_tdata[5], want.held);
        if (m_axis_tdata[6] != want.any)    report_mismatch("any_held", m_axis_tdata[6], want.any);
        if (m_axis_tdata[7] != 1'b0)        report_mismatch("pad bit", m_axis_tdata[7], 0);
        if (m_axis_tlast != want.last)      report_mismatch("tlast", m_axis_tlast, want.last);
      end
    end
  end

  // Sink: stall pattern in random spans, one long hold-off on request
  initial begin : sink
    sink_mode_e mode;
    int         span;
    m_axis_tready = 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end
      mode = sink_mode_e'($urandom_range(0, 3));
      span = $urandom_range(8, 40);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          SINK_OPEN:   m_axis_tready <= 1'b1;
          SINK_HALF:   m_axis_tready <= ($urandom_range(0, 1) == 1);
          SINK_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:     m_axis_tready <= ~m_axis_tready;
        endcase
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any transfer
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("multi_key_press_classifier_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    deb_cfg       = mkpc_pkg::DEBOUNCE_RST;
    lng_cfg       = mkpc_pkg::LONG_PRESS_RST;
    for (int k = 0; k < mkpc_pkg::KEY_COUNT; k++) begin
      key_mode[k]  = mkpc_pkg::M_IDLE;
      key_stamp[k] = '0;
      key_valid[k] = 1'b0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        write_reg(dir_rows[r].idx, dir_rows[r].val);
      end else begin
        send_tick(dir_rows[r].ts, dir_rows[r].pins, dir_rows[r].chk, dir_rows[r].held,
                  dir_rows[r].ev_short, dir_rows[r].ev_long);
        sender_idle();
      end
    end

    // Random phases over several register settings
    write_reg(mkpc_pkg::CFG_DEBOUNCE, 16'hFFFF);
    write_reg(mkpc_pkg::CFG_LONG_PRESS, 16'hFFFF);
    write_reg({mkpc_pkg::CFG_IDX_W{1'b1}}, mkpc_pkg::CFG_W'($urandom));
    random_phase(18, 1'b0);

    write_reg(mkpc_pkg::CFG_DEBOUNCE, mkpc_pkg::CFG_W'($urandom_range(0, 40)));
    write_reg(mkpc_pkg::CFG_LONG_PRESS, mkpc_pkg::CFG_W'($urandom_range(0, 300)));
    hold_req = 1'b1;
    random_phase(18, 1'b1);

    write_reg(mkpc_pkg::CFG_DEBOUNCE, 16'd0);
    write_reg(mkpc_pkg::CFG_LONG_PRESS, 16'hFFFF);
    random_phase(18, 1'b0);

    write_reg(mkpc_pkg::CFG_DEBOUNCE, mkpc_pkg::CFG_W'($urandom));
    write_reg(mkpc_pkg::CFG_LONG_PRESS, mkpc_pkg::CFG_W'($urandom));
    random_phase(18, 1'b0);

    write_reg(mkpc_pkg::CFG_DEBOUNCE, 16'd1);
    write_reg(mkpc_pkg::CFG_LONG_PRESS, 16'd0);
    random_phase(18, 1'b0);

    // Drain and finish
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (key_report_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("multi_key_press_classifier_tb: done, clean");
    else
      $display("multi_key_press_classifier_tb: done, errors");
    $finish;
  end

endmodule

// File: files.f
src/mkpc_pkg.sv
src/mkpc_state_ram.sv
src/mkpc_engine.sv
src/multi_key_press_classifier.sv
tb/multi_key_press_classifier_tb.sv
